// ===== rtl/ipwr_pkg.sv =====
// ----------------------------------------------------------------------------
// ipwr_pkg
// Shared types and constants for the pulse-width infrared message receiver.
// ----------------------------------------------------------------------------
package ipwr_pkg;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = 11;
  localparam int CNT_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_MIN    = 3'd0,
    REG_ZERO_MAX    = 3'd1,
    REG_ONE_MIN     = 3'd2,
    REG_ONE_MAX     = 3'd3,
    REG_SYNC_MIN    = 3'd4,
    REG_SYNC_MAX    = 3'd5,
    REG_SYNCS_DATA  = 3'd6,
    REG_SYNCS_DONE  = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [LEN_W-1:0] ZERO_MIN_RST   = 11'd50;
  localparam logic [LEN_W-1:0] ZERO_MAX_RST   = 11'd350;
  localparam logic [LEN_W-1:0] ONE_MIN_RST    = 11'd400;
  localparam logic [LEN_W-1:0] ONE_MAX_RST    = 11'd700;
  localparam logic [LEN_W-1:0] SYNC_MIN_RST   = 11'd750;
  localparam logic [LEN_W-1:0] SYNC_MAX_RST   = 11'd1250;
  localparam logic [CNT_W-1:0] SYNCS_DATA_RST = 8'd5;
  localparam logic [CNT_W-1:0] SYNCS_DONE_RST = 8'd10;

  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    PC_NONE = 3'd0,
    PC_ZERO = 3'd1,
    PC_ONE  = 3'd2,
    PC_SYNC = 3'd3,
    PC_BAD  = 3'd4
  } pulse_class_t;

  // classified request from the front to the back
  typedef struct packed {
    logic         release_req;
    pulse_class_t cls;
  } item_t;

  // one result
  typedef struct packed {
    pulse_class_t cls;
    logic         stored;
    logic [1:0]   index;
    logic [7:0]   value;
    logic         done;
    logic         ok;
    logic         pending;
  } result_t;

endpackage

// ===== rtl/ir_pulse_width_message_receiver_core.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_width_message_receiver_core
// Decodes pulse-width infrared frames from timestamped line edges.
// ----------------------------------------------------------------------------
// Flow: a taken request goes into the middle queue, and the frame logic takes
// it when the result queue has room; that queue's head drives the result ports.
// Throughput: one request per cycle while full is low; the front classifier and
// the frame state logic each decide a request combinationally.
// Reset: rst clears all frame state, slots and queues, and loads the
// register defaults; the block takes requests in the cycle after reset.
module ir_pulse_width_message_receiver_core #(
  parameter int PAYLOAD_BYTES = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           op,
  input  logic                           level,
  input  logic [7:0]                     timestamp,
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     pulse_class,
  output logic                           byte_stored,
  output logic [1:0]                     byte_index,
  output logic [7:0]                     byte_value,
  output logic                           message_done,
  output logic                           checksum_ok,
  output logic                           pending,
  input  logic                           cfg_write,
  input  logic [ipwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipwr_pkg::CFG_W-1:0]     cfg_data
);

  import ipwr_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  item_t   front_item;
  item_t   mid_item;
  result_t back_result;
  result_t out_result;
  logic    accept;
  logic    mid_empty;
  logic    out_full;
  logic    back_go;

  assign accept  = push && !full;
  assign back_go = !mid_empty && !out_full;

  // front: timing and classification
  ipwr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op),
    .level     (level),
    .timestamp (timestamp),
    .item      (front_item)
  );

  // queue between classifier and frame logic
  ipwr_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_item),
    .full  (full),
    .pop   (back_go),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  // back: frame state
  ipwr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (back_go),
    .item      (mid_item),
    .result    (back_result)
  );

  // result queue
  ipwr_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (back_go),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_result),
    .empty (empty)
  );

  // result fields
  assign pulse_class  = out_result.cls;
  assign byte_stored  = out_result.stored;
  assign byte_index   = out_result.index;
  assign byte_value   = out_result.value;
  assign message_done = out_result.done;
  assign checksum_ok  = out_result.ok;
  assign pending      = out_result.pending;

endmodule

// ===== rtl/ipwr_fifo.sv =====
// ----------------------------------------------------------------------------
// ipwr_fifo
// Small synchronous queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ipwr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ipwr_front.sv =====
// ----------------------------------------------------------------------------
// ipwr_front
// Takes line edges and releases, measures low pulses and classifies them.
// ----------------------------------------------------------------------------
module ipwr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ipwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipwr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           accept,
  input  logic                           op,
  input  logic                           level,
  input  logic [7:0]                     timestamp,
  output ipwr_pkg::item_t                item
);

  import ipwr_pkg::*;

  logic [LEN_W-1:0] zero_min;
  logic [LEN_W-1:0] zero_max;
  logic [LEN_W-1:0] one_min;
  logic [LEN_W-1:0] one_max;
  logic [LEN_W-1:0] sync_min;
  logic [LEN_W-1:0] sync_max;
  logic [7:0]       last_edge_time;
  logic [7:0]       ticks;
  logic [LEN_W-1:0] len;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_min <= ZERO_MIN_RST;
      zero_max <= ZERO_MAX_RST;
      one_min  <= ONE_MIN_RST;
      one_max  <= ONE_MAX_RST;
      sync_min <= SYNC_MIN_RST;
      sync_max <= SYNC_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZERO_MIN: zero_min <= cfg_data;
        REG_ZERO_MAX: zero_max <= cfg_data;
        REG_ONE_MIN:  one_min  <= cfg_data;
        REG_ONE_MAX:  one_max  <= cfg_data;
        REG_SYNC_MIN: sync_min <= cfg_data;
        REG_SYNC_MAX: sync_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // every edge restarts the pulse timer, pending or not
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
    end else if (accept && !op) begin
      last_edge_time <= timestamp;
    end
  end

  // pulse length in us, 8 us per tick with 8-bit wrap
  assign ticks = timestamp - last_edge_time;
  assign len   = {ticks, 3'b000};

  // classification, first match wins
  always_comb begin
    item.release_req = op;
    item.cls         = PC_NONE;
    if (!op && level) begin
      if (len > zero_min && len <= zero_max) begin
        item.cls = PC_ZERO;
      end else if (len > one_min && len <= one_max) begin
        item.cls = PC_ONE;
      end else if (len > sync_min && len < sync_max) begin
        item.cls = PC_SYNC;
      end else begin
        item.cls = PC_BAD;
      end
    end
  end

endmodule

// ===== rtl/ipwr_back.sv =====
// ----------------------------------------------------------------------------
// ipwr_back
// Frame state: sync counting, bit shifting, byte slots, checksum, release.
// ----------------------------------------------------------------------------
module ipwr_back #(
  parameter int PAYLOAD_BYTES = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ipwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipwr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           go,
  input  ipwr_pkg::item_t                item,
  output ipwr_pkg::result_t              result
);

  import ipwr_pkg::*;

  localparam int SLOTS = PAYLOAD_BYTES + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam logic [7:0] FILL_XOR = (PAYLOAD_BYTES % 2 == 1) ? FILL_BYTE : 8'h00;

  logic [CNT_W-1:0] syncs_data;
  logic [CNT_W-1:0] syncs_done;
  logic [CNT_W-1:0] sync_count;
  logic [CNT_W-1:0] sync_count_next;
  logic [7:0]       shift_byte;
  logic [7:0]       shift_byte_next;
  logic [3:0]       bit_count;
  logic [3:0]       bit_count_next;
  logic [SW-1:0]    write_slot;
  logic [SW-1:0]    write_slot_next;
  logic             held;
  logic             held_next;
  logic [7:0]       chk;
  logic [7:0]       chk_next;
  logic [7:0]       slots [SLOTS];
  logic             store;
  logic [SW-1:0]    store_slot;
  logic             fill;
  logic [SW+1:0]    slot_ext;

  // frame count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      syncs_data <= SYNCS_DATA_RST;
      syncs_done <= SYNCS_DONE_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SYNCS_DATA: syncs_data <= cfg_data[CNT_W-1:0];
        REG_SYNCS_DONE: syncs_done <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next frame state and the result of this request
  always_comb begin
    sync_count_next = sync_count;
    shift_byte_next = shift_byte;
    bit_count_next  = bit_count;
    write_slot_next = write_slot;
    held_next       = held;
    chk_next        = chk;
    store           = 1'b0;
    store_slot      = '0;
    fill            = 1'b0;
    result          = '0;
    result.cls      = PC_NONE;

    if (item.release_req) begin
      // release acts only while a message is held
      if (held) begin
        result.ok = (chk == 8'h00);
        fill      = (chk == 8'h00);
        held_next = 1'b0;
        if (chk == 8'h00) begin
          chk_next = slots[SLOTS-1] ^ FILL_XOR;
        end
      end
    end else if (item.cls != PC_NONE && !held) begin
      result.cls = item.cls;
      case (item.cls) inside
        PC_ZERO, PC_ONE: begin
          if (sync_count > syncs_data) begin
            shift_byte_next = {shift_byte[6:0], (item.cls == PC_ONE)};
            bit_count_next  = bit_count + 1'b1;
          end
        end
        PC_SYNC: begin
          if (sync_count != {CNT_W{1'b1}}) begin
            sync_count_next = sync_count + 1'b1;
          end
          if (write_slot != '0) begin
            if (sync_count_next > syncs_done) begin
              held_next       = 1'b1;
              sync_count_next = '0;
              write_slot_next = '0;
              result.done     = 1'b1;
              result.ok       = (chk == 8'h00);
            end
          end else begin
            shift_byte_next = '0;
            bit_count_next  = '0;
            write_slot_next = '0;
          end
        end
        default: begin
          sync_count_next = '0;
        end
      endcase

      // a complete byte goes to the current slot
      if (sync_count_next > syncs_data && bit_count_next == BITS_PER_BYTE) begin
        store          = 1'b1;
        store_slot     = write_slot_next;
        bit_count_next = '0;
        chk_next       = chk ^ slots[write_slot_next] ^ shift_byte_next;
        result.stored  = 1'b1;
        result.value   = shift_byte_next;
        if (write_slot_next < SW'(PAYLOAD_BYTES)) begin
          write_slot_next = write_slot_next + 1'b1;
        end
      end
    end
    slot_ext       = (SW + 2)'(store_slot);
    result.pending = held_next;
    result.index   = slot_ext[1:0];
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_count <= '0;
      shift_byte <= '0;
      bit_count  <= '0;
      write_slot <= '0;
      held       <= 1'b0;
      chk        <= '0;
    end else if (go) begin
      sync_count <= sync_count_next;
      shift_byte <= shift_byte_next;
      bit_count  <= bit_count_next;
      write_slot <= write_slot_next;
      held       <= held_next;
      chk        <= chk_next;
    end
  end

  // message slots; the last one holds the checksum byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (go) begin
      if (fill) begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          slots[i] <= FILL_BYTE;
        end
      end else if (store) begin
        slots[store_slot] <= shift_byte_next;
      end
    end
  end

endmodule

// ===== sim/ir_pulse_width_message_receiver_core_test.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_width_message_receiver_core_test
// Self-checking bench for the pulse-width infrared receiver. A short table of
// edges and releases runs first, then random frames and requests under several
// threshold settings, each result checked against its table row or the decoder.
// ----------------------------------------------------------------------------
module ir_pulse_width_message_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ipwr_pkg::*;

  localparam int PAYLOAD     = 3;
  localparam int SLOTS       = PAYLOAD + 1;
  localparam int MAX_GAP     = 18;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int DIR_SPLIT   = 9;

  typedef struct {
    logic       op;
    logic       level;
    logic [7:0] ts;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       push        = 1'b0;
  logic       op          = 1'b0;
  logic       level       = 1'b0;
  logic [7:0] timestamp   = 8'h00;
  logic       pop         = 1'b0;
  logic       cfg_write   = 1'b0;
  cfg_reg_t   cfg_index   = REG_ZERO_MIN;
  logic [CFG_W-1:0] cfg_data = '0;
  logic       full;
  logic       empty;
  logic [2:0] pulse_class;
  logic       byte_stored;
  logic [1:0] byte_index;
  logic [7:0] byte_value;
  logic       message_done;
  logic       checksum_ok;
  logic       pending;

  // decoder copy: thresholds and frame state
  int         cf_zero_min, cf_zero_max, cf_one_min, cf_one_max;
  int         cf_sync_min, cf_sync_max;
  logic [7:0] cf_syncs_data, cf_syncs_done;
  logic [7:0] rx_last, rx_syncs, rx_shift;
  logic [1:0] rx_slot;
  logic [3:0] rx_bits;
  logic       rx_held;
  logic [7:0] rx_slots [0:SLOTS-1];

  result_t    decode_q [$];
  logic [7:0] line_time = 8'h00;
  bit         src_burst = 1'b0;
  bit         snk_burst = 1'b0;
  int         sent_count = 0;
  int         checked_count = 0;
  int         err_count = 0;
  int         msg_count = 0;
  int         byte_count = 0;
  int         settings_count = 0;
  int         stall_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  ir_pulse_width_message_receiver_core #(.PAYLOAD_BYTES(PAYLOAD)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .level(level),
    .timestamp(timestamp), .empty(empty), .pop(pop), .pulse_class(pulse_class),
    .byte_stored(byte_stored), .byte_index(byte_index), .byte_value(byte_value),
    .message_done(message_done), .checksum_ok(checksum_ok), .pending(pending),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------- decoder

  function automatic pulse_class_t classify_len(int len);
    if (len > cf_zero_min && len <= cf_zero_max) return PC_ZERO;
    else if (len > cf_one_min && len <= cf_one_max) return PC_ONE;
    else if (len > cf_sync_min && len < cf_sync_max) return PC_SYNC;
    else return PC_BAD;
  endfunction

  function automatic logic slots_clear();
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < SLOTS; i++) acc ^= rx_slots[i];
    return acc == 8'h00;
  endfunction

  function automatic result_t plain(pulse_class_t c);
    result_t r;
    r = '0;
    r.cls = c;
    return r;
  endfunction

  // one request through the frame decoder, returns its result
  function automatic result_t decode_edge(logic o, logic l, logic [7:0] ts);
    result_t      r;
    logic [7:0]   ticks;
    pulse_class_t c;
    r = '0;
    if (o) begin
      // release: only acts on a held message
      if (rx_held) begin
        r.ok = slots_clear();
        if (r.ok)
          for (int i = 0; i < PAYLOAD; i++) rx_slots[i] = FILL_BYTE;
        rx_held = 1'b0;
      end
    end else if (!l) begin
      rx_last = ts;
    end else begin
      ticks = ts - rx_last;
      rx_last = ts;
      if (!rx_held) begin
        c = classify_len(int'(ticks) * 8);
        r.cls = c;
        case (c) inside
          PC_ZERO, PC_ONE: begin
            if (rx_syncs > cf_syncs_data) begin
              rx_shift = {rx_shift[6:0], (c == PC_ONE)};
              rx_bits = rx_bits + 4'd1;
            end
          end
          PC_SYNC: begin
            if (rx_syncs != 8'hFF) rx_syncs = rx_syncs + 8'd1;
            if (rx_slot != 2'd0) begin
              // closing sync
              if (rx_syncs > cf_syncs_done) begin
                rx_held = 1'b1;
                rx_syncs = 8'd0;
                rx_slot = 2'd0;
                r.done = 1'b1;
                r.ok = slots_clear();
                msg_count++;
              end
            end else begin
              rx_shift = 8'd0;
              rx_bits = 4'd0;
            end
          end
          default: begin
            rx_syncs = 8'd0;
          end
        endcase
        // byte complete
        if (rx_syncs > cf_syncs_data && rx_bits == BITS_PER_BYTE) begin
          rx_bits = 4'd0;
          rx_slots[rx_slot] = rx_shift;
          r.stored = 1'b1;
          r.index = rx_slot;
          r.value = rx_shift;
          byte_count++;
          if (rx_slot < PAYLOAD) rx_slot = rx_slot + 2'd1;
        end
      end
    end
    r.pending = rx_held;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // pulse length in ticks that lands in the wanted class, edges favored
  function automatic logic [7:0] pulse_ticks(pulse_class_t c);
    int lo, hi, t;
    case (c)
      PC_ZERO: begin lo = cf_zero_min / 8 + 1; hi = cf_zero_max / 8; end
      PC_ONE:  begin lo = cf_one_min / 8 + 1;  hi = cf_one_max / 8;  end
      PC_SYNC: begin lo = cf_sync_min / 8 + 1; hi = (cf_sync_max - 1) / 8; end
      default: begin lo = 0; hi = 255; end
    endcase
    if (hi > 255) hi = 255;
    t = 0;
    for (int n = 0; n < 32; n++) begin
      if (lo <= hi) begin
        case ($urandom_range(0, 7))
          0: t = lo;
          1: t = hi;
          default: t = $urandom_range(hi, lo);
        endcase
      end else begin
        t = $urandom_range(255, 0);
      end
      if (classify_len(t * 8) == c) break;
    end
    return 8'(t);
  endfunction

  function automatic pulse_class_t any_class();
    case ($urandom_range(0, 3))
      0: return PC_ZERO;
      1: return PC_ONE;
      2: return PC_SYNC;
      default: return PC_BAD;
    endcase
  endfunction

  // drive one request, wait for it to be taken, queue what it should decode to
  task automatic send_req(input logic o, input logic l, input logic [7:0] ts,
                          input bit typed, input result_t want);
    int      gap;
    result_t pred;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    op <= o;
    level <= l;
    timestamp <= ts;
    @(posedge clk);
    while (full) @(posedge clk);
    pred = decode_edge(o, l, ts);
    decode_q.push_back(typed ? want : pred);
    sent_count++;
  endtask

  // falling then rising edge around a low pulse of the given class
  task automatic send_pulse(input pulse_class_t c);
    logic [7:0] ticks;
    ticks = pulse_ticks(c);
    send_req(1'b0, 1'b0, line_time, 1'b0, '0);
    line_time = line_time + ticks;
    send_req(1'b0, 1'b1, line_time, 1'b0, '0);
    line_time = line_time + 8'($urandom_range(1, 255));
  endtask

  // eight data bits msb first, now and then a stray pulse breaks the frame
  task automatic send_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      if ($urandom_range(0, 199) == 0) send_pulse($urandom_range(0, 1) ? PC_BAD : PC_SYNC);
      send_pulse(b[i] ? PC_ONE : PC_ZERO);
    end
  endtask

  // lead syncs, payload and checksum, closing syncs, then usually a release
  task automatic send_frame();
    int         lead, nbytes, tries;
    logic [7:0] pay [0:4];
    lead = int'(cf_syncs_data) + 1 + $urandom_range(0, 2);
    nbytes = ($urandom_range(0, 9) < 7) ? SLOTS : $urandom_range(1, 5);
    for (int i = 0; i < 5; i++) begin
      case ($urandom_range(0, 7))
        0: pay[i] = 8'h00;
        1: pay[i] = 8'hFF;
        default: pay[i] = 8'($urandom);
      endcase
    end
    if ($urandom_range(0, 3) != 0) pay[PAYLOAD] = pay[0] ^ pay[1] ^ pay[2];
    repeat (lead) send_pulse(PC_SYNC);
    for (int i = 0; i < nbytes; i++) send_byte(pay[i]);
    tries = 0;
    while (!rx_held && tries < 24) begin
      send_pulse(PC_SYNC);
      tries++;
    end
    if (rx_held) begin
      // edges while held are dropped
      repeat ($urandom_range(0, 2)) send_pulse(any_class());
      if ($urandom_range(0, 19) != 0)
        send_req(1'b1, 1'($urandom), 8'($urandom), 1'b0, '0);
    end
  endtask

  task automatic run_traffic(input int n);
    int start, pick;
    start = sent_count;
    while (sent_count - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80 && cf_syncs_data < 200 && cf_syncs_done < 200) send_frame();
      else if (pick < 92) send_pulse(any_class());
      else send_req(1'($urandom), 1'($urandom), 8'($urandom), 1'b0, '0);
    end
  endtask

  // let every result drain, then load all eight registers
  task automatic apply_settings(input int zmin, input int zmax, input int omin,
                                input int omax, input int smin, input int smax,
                                input int sdata, input int sdone);
    int       vals [0:7];
    cfg_reg_t regs [0:7];
    vals = '{zmin, zmax, omin, omax, smin, smax, sdata, sdone};
    regs = '{REG_ZERO_MIN, REG_ZERO_MAX, REG_ONE_MIN, REG_ONE_MAX,
             REG_SYNC_MIN, REG_SYNC_MAX, REG_SYNCS_DATA, REG_SYNCS_DONE};
    push <= 1'b0;
    while (decode_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= 11'(vals[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cf_zero_min = zmin & 'h7FF;
    cf_zero_max = zmax & 'h7FF;
    cf_one_min = omin & 'h7FF;
    cf_one_max = omax & 'h7FF;
    cf_sync_min = smin & 'h7FF;
    cf_sync_max = smax & 'h7FF;
    cf_syncs_data = 8'(sdata);
    cf_syncs_done = 8'(sdone);
    settings_count++;
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin : stimulus
    dir_row_t dir_tab [$];
    int       a, b, c, d, e, f;
    // decoder at reset
    cf_zero_min = ZERO_MIN_RST;
    cf_zero_max = ZERO_MAX_RST;
    cf_one_min = ONE_MIN_RST;
    cf_one_max = ONE_MAX_RST;
    cf_sync_min = SYNC_MIN_RST;
    cf_sync_max = SYNC_MAX_RST;
    cf_syncs_data = SYNCS_DATA_RST;
    cf_syncs_done = SYNCS_DONE_RST;
    rx_last = 8'd0;
    rx_syncs = 8'd0;
    rx_shift = 8'd0;
    rx_slot = 2'd0;
    rx_bits = 4'd0;
    rx_held = 1'b0;
    for (int i = 0; i < SLOTS; i++) rx_slots[i] = 8'd0;

    // reset defaults: release with nothing held, zero length, wrapped zero,
    // longest pulse, one bit
    dir_tab.push_back('{1'b1, 1'b1, 8'hFF, 1'b1, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b0, 8'h00, 1'b1, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b1, 8'h00, 1'b1, plain(PC_BAD)});
    dir_tab.push_back('{1'b0, 1'b0, 8'hFA, 1'b1, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b1, 8'h04, 1'b1, plain(PC_ZERO)});
    dir_tab.push_back('{1'b0, 1'b0, 8'h00, 1'b1, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b1, 8'hFF, 1'b1, plain(PC_BAD)});
    dir_tab.push_back('{1'b0, 1'b0, 8'h00, 1'b1, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b1, 8'h3C, 1'b1, plain(PC_ONE)});
    // one sync, a zero byte, closing sync, edge while held, two releases
    dir_tab.push_back('{1'b0, 1'b0, 8'h00, 1'b0, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b1, 8'h64, 1'b0, plain(PC_NONE)});
    for (int k = 0; k < 8; k++) begin
      dir_tab.push_back('{1'b0, 1'b0, 8'h00, 1'b0, plain(PC_NONE)});
      dir_tab.push_back('{1'b0, 1'b1, 8'h0A, 1'b0, plain(PC_NONE)});
    end
    dir_tab.push_back('{1'b0, 1'b0, 8'h00, 1'b0, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b1, 8'h64, 1'b0, plain(PC_NONE)});
    dir_tab.push_back('{1'b0, 1'b1, 8'hFF, 1'b0, plain(PC_NONE)});
    dir_tab.push_back('{1'b1, 1'b0, 8'h00, 1'b0, plain(PC_NONE)});
    dir_tab.push_back('{1'b1, 1'b1, 8'h55, 1'b1, plain(PC_NONE)});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < dir_tab.size(); i++) begin
      if (i == DIR_SPLIT) apply_settings(50, 350, 400, 700, 750, 1250, 0, 0);
      send_req(dir_tab[i].op, dir_tab[i].level, dir_tab[i].ts, dir_tab[i].typed,
               dir_tab[i].want);
    end

    // reset thresholds, written back explicitly
    apply_settings(ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST,
                   SYNC_MIN_RST, SYNC_MAX_RST, SYNCS_DATA_RST, SYNCS_DONE_RST);
    run_traffic(300);

    // lowest limits: zero threshold at 0, sync open to the top, no sync counts
    apply_settings(0, 200, 200, 600, 600, 2047, 0, 0);
    run_traffic(200);

    // sync count saturation, then bytes past the last slot
    apply_settings(0, 300, 300, 700, 700, 2047, 254, 255);
    repeat (258) send_pulse(PC_SYNC);
    repeat (5) send_byte(8'($urandom));
    repeat (3) send_pulse(PC_SYNC);
    run_traffic(40);

    // everything at the top: no pulse classifies
    apply_settings(2047, 2047, 2047, 2047, 2047, 2047, 255, 255);
    run_traffic(30);

    // random thresholds, ordered most of the time, overlapping otherwise
    repeat (4) begin
      if ($urandom_range(0, 3) == 0) begin
        a = $urandom_range(0, 400);
        b = $urandom_range(0, 1200);
        c = $urandom_range(0, 800);
        d = $urandom_range(0, 1600);
        e = $urandom_range(0, 1200);
        f = $urandom_range(0, 2047);
      end else begin
        a = $urandom_range(0, 300);
        b = a + $urandom_range(16, 500);
        c = b + $urandom_range(0, 100);
        d = c + $urandom_range(16, 500);
        e = d + $urandom_range(0, 100);
        f = e + $urandom_range(16, 900);
        if (f > 2047) f = 2047;
      end
      apply_settings(a, b, c, d, e, f, $urandom_range(0, 8), $urandom_range(0, 12));
      run_traffic(100);
    end

    // drain and close
    push <= 1'b0;
    while (decode_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d requests over %0d register settings, %0d results compared",
             sent_count, settings_count, checked_count);
    $display("decoder completed %0d messages and stored %0d bytes, %0d errors",
             msg_count, byte_count, err_count);
    if (err_count == 0 && decode_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------- checking

  // result side: random pop stalls, compare each accepted result in order
  initial begin : result_sink
    int      gap;
    result_t want;
    forever begin
      if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
      gap = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (decode_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: result with no request outstanding, class %0d", $time,
                   pulse_class);
      end else begin
        want = decode_q.pop_front();
        checked_count++;
        if (pulse_class !== want.cls || byte_stored !== want.stored ||
            byte_index !== want.index || byte_value !== want.value ||
            message_done !== want.done || checksum_ok !== want.ok ||
            pending !== want.pending) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp cls=%0d st=%0d idx=%0d val=%02h done=%0d ok=%0d pend=%0d",
                     $time, want.cls, want.stored, want.index, want.value, want.done,
                     want.ok, want.pending);
            $display("%0t:          got cls=%0d st=%0d idx=%0d val=%02h done=%0d ok=%0d pend=%0d",
                     $time, pulse_class, byte_stored, byte_index, byte_value,
                     message_done, checksum_ok, pending);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 stall_cycles, decode_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== ir_pulse_width_message_receiver_core.f =====
rtl/ipwr_pkg.sv
rtl/ipwr_fifo.sv
rtl/ipwr_front.sv
rtl/ipwr_back.sv
rtl/ir_pulse_width_message_receiver_core.sv
sim/ir_pulse_width_message_receiver_core_test.sv
